>>> src/prq_pkg.sv
// Package for the process ready queue: sizes, operation and status codes,
// sequencer states and the structs the sequencer passes to the slots and to the top level.
// No dependencies.
package prq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ID_BITS  = 8;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned FIELD_W  = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_POP    = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } slot_wr_t;

  typedef struct packed {
    status_e              status;
    logic [FIELD_W-1:0]   pid;
    logic [PRIO_W-1:0]    prio;
    logic [COUNT_W-1:0]   count;
  } result_t;

  function automatic logic [ID_BITS-1:0] to_id(input logic [FIELD_W-1:0] v);
    logic [ID_BITS+FIELD_W-1:0] w;
    w = (ID_BITS + FIELD_W)'(v);
    return w[ID_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] from_id(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+FIELD_W-1:0] w;
    w = (ID_BITS + FIELD_W)'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] v);
    logic [CNT_W+COUNT_W-1:0] w;
    w = (CNT_W + COUNT_W)'(v);
    return w[COUNT_W-1:0];
  endfunction

endpackage

>>> src/prq_slots.sv
// Slot storage of the ready queue: id and priority per slot, slot 0 is the head.
// One write port and one read port. Depends on prq_pkg.
module prq_slots (
  input  logic                          clk_i,
  input  prq_pkg::slot_wr_t             wr_i,
  input  logic [prq_pkg::IDX_W-1:0]     rd_addr_i,
  output logic [prq_pkg::ID_BITS-1:0]   rd_id_o,
  output logic [prq_pkg::PRIO_W-1:0]    rd_prio_o
);
  import prq_pkg::*;

  logic [ID_BITS-1:0] ids_q   [DEPTH];
  logic [PRIO_W-1:0]  prios_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ids_q[wr_i.addr]   <= wr_i.id;
      prios_q[wr_i.addr] <= wr_i.prio;
    end
  end

  assign rd_id_o   = ids_q[rd_addr_i];
  assign rd_prio_o = prios_q[rd_addr_i];

endmodule

>>> src/prq_seq.sv
// Sequencer of the ready queue: decodes the operation, scans slots with one
// id comparator, closes gaps one slot per cycle and tracks occupancy. Depends on prq_pkg.
module prq_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [prq_pkg::FIELD_W-1:0]   process_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]    priority_req_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output prq_pkg::result_t              res_o,
  output prq_pkg::slot_wr_t             wr_o,
  output logic [prq_pkg::IDX_W-1:0]     rd_addr_o,
  input  logic [prq_pkg::ID_BITS-1:0]   rd_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]    rd_prio_i
);
  import prq_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [ID_BITS-1:0] pid_q, pid_d;
  status_e            status_q, status_d;
  logic [FIELD_W-1:0] rid_q, rid_d;
  logic [PRIO_W-1:0]  rprio_q, rprio_d;
  logic [CNT_W-1:0]   idx_next;
  logic               accept;
  logic               match;

  assign accept   = in_valid_i && !in_stall_o;
  assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
  assign match    = (rd_id_i == pid_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = '{status: status_q, pid: rid_q, prio: rprio_q, count: to_count(occ_q)};

  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr_o = '0;
      S_SHIFT: rd_addr_o = idx_next[IDX_W-1:0];
      default: rd_addr_o = idx_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    pid_d     = pid_q;
    status_d  = status_q;
    rid_d     = rid_q;
    rprio_d   = rprio_q;
    wr_o      = '{en: 1'b0, addr: idx_q, id: rd_id_i, prio: rd_prio_i};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pid_d    = to_id(process_id_i);
          idx_d    = '0;
          status_d = ST_DONE;
          rid_d    = '0;
          rprio_d  = '0;
          state_d  = S_RESP;
          case (kind_e'(kind_i))
            KIND_INSERT: begin
              if (occ_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_o  = '{en: 1'b1, addr: occ_q[IDX_W-1:0],
                          id: to_id(process_id_i), prio: priority_req_i};
                occ_d = occ_q + CNT_W'(1);
              end
            end
            KIND_REMOVE: begin
              if (occ_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_POP: begin
              if (occ_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                rid_d   = from_id(rd_id_i);
                rprio_d = rd_prio_i;
                state_d = S_SHIFT;
              end
            end
            default: begin
              status_d = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_d = S_SHIFT;
        end else if (idx_next == occ_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        if (idx_next < occ_q) begin
          wr_o.en = 1'b1;
          idx_d   = idx_next[IDX_W-1:0];
        end else begin
          occ_d   = occ_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pid_q    <= pid_d;
    status_q <= status_d;
    rid_q    <= rid_d;
    rprio_q  <= rprio_d;
  end

endmodule

>>> src/process_ready_queue.sv
// Process ready queue: a bounded FIFO of up to DEPTH scheduler entries (id, priority)
// with insert at tail, remove of the first matching id and pop of the head.
// Every item gives one result with a status and the entry count. One item is
// worked at a time by a sequencer with a single id comparator and one slot read
// port, moving one slot per cycle: insert and any empty, full or unused-kind case
// go straight to the result; pop takes the head and shifts the rest forward;
// remove scans up to the match, then closes the gap behind it. A finished result
// sits in an output register, so the next item is taken while it waits. Depends on
// prq_pkg, prq_seq and prq_slots.
module process_ready_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [prq_pkg::FIELD_W-1:0]   process_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]    priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prq_pkg::STATUS_W-1:0]  status_o,
  output logic [prq_pkg::FIELD_W-1:0]   out_process_id_o,
  output logic [prq_pkg::PRIO_W-1:0]    out_priority_o,
  output logic [prq_pkg::COUNT_W-1:0]   count_o
);
  import prq_pkg::*;

  slot_wr_t           wr;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_id;
  logic [PRIO_W-1:0]  rd_prio;
  logic               res_valid;
  logic               res_take;
  result_t            res;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  prq_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .process_id_i   (process_id_i),
    .priority_req_i (priority_req_i),
    .res_valid_o    (res_valid),
    .res_take_i     (res_take),
    .res_o          (res),
    .wr_o           (wr),
    .rd_addr_o      (rd_addr),
    .rd_id_i        (rd_id),
    .rd_prio_i      (rd_prio)
  );

  prq_slots u_slots (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_id_o   (rd_id),
    .rd_prio_o (rd_prio)
  );

  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign out_process_id_o = out_q.pid;
  assign out_priority_o   = out_q.prio;
  assign count_o          = out_q.count;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for process_ready_queue: drives insert, remove-by-id, pop and
// unused operations with random idling on both sides and checks every reply against
// a queue-based prediction. Depends on prq_pkg and the process_ready_queue RTL.
module tb_top;
  import prq_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } slot_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic [1:0]          kind_i         = 2'd0;
  logic [FIELD_W-1:0]  process_id_i   = '0;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic                out_stall_i    = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  out_process_id_o;
  logic [PRIO_W-1:0]   out_priority_o;
  logic [COUNT_W-1:0]  count_o;

  slot_t   sched_q[$];
  result_t replies_due[$];
  int      errors = 0;
  int      items_sent = 0;
  int      replies_seen = 0;
  int      rx_wait = 0;
  int      cycle_count = 0;
  int      status_seen[4] = '{0, 0, 0, 0};
  bit      no_gaps = 1'b0;
  logic    long_hold = 1'b0;

  process_ready_queue u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .process_id_i     (process_id_i),
    .priority_req_i   (priority_req_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_process_id_o (out_process_id_o),
    .out_priority_o   (out_priority_o),
    .count_o          (count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t queue_reply(input logic [1:0] kind,
                                          input logic [FIELD_W-1:0] pid,
                                          input logic [PRIO_W-1:0] prio);
    result_t r;
    slot_t   head;
    int      hit;
    r = '0;
    r.status = ST_DONE;
    hit = -1;
    case (kind)
      KIND_INSERT: begin
        if (sched_q.size() >= DEPTH) r.status = ST_FULL;
        else sched_q.push_back('{id: pid[ID_BITS-1:0], prio: prio});
      end
      KIND_REMOVE: begin
        if (sched_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < sched_q.size(); k++)
            if (hit < 0 && sched_q[k].id == pid[ID_BITS-1:0]) hit = k;
          if (hit < 0) r.status = ST_NOT_FOUND;
          else sched_q.delete(hit);
        end
      end
      KIND_POP: begin
        if (sched_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head = sched_q.pop_front();
          r.pid = FIELD_W'(head.id);
          r.prio = head.prio;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(sched_q.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_reply();
    result_t want;
    replies_seen++;
    if (replies_due.size() == 0) begin
      report_mismatch("reply with none due", status_o, 0);
    end else begin
      want = replies_due.pop_front();
      status_seen[want.status]++;
      if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      if (out_process_id_o !== want.pid)
        report_mismatch("process id", out_process_id_o, want.pid);
      if (out_priority_o !== want.prio) report_mismatch("priority", out_priority_o, want.prio);
      if (count_o !== want.count) report_mismatch("count", count_o, want.count);
    end
  endtask

  // drain replies: hold off a random number of cycles after each unless no_gaps is set, or for a long stretch
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_reply();
      rx_wait = no_gaps ? 0 : $urandom_range(0, 8);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= (rx_wait > 0) || long_hold;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d replies outstanding", $time, replies_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_op(input logic [1:0] kind, input logic [FIELD_W-1:0] pid,
                         input logic [PRIO_W-1:0] prio);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    process_id_i   <= pid;
    priority_req_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    replies_due.push_back(queue_reply(kind, pid, prio));
    items_sent++;
  endtask

  task automatic send_random_op(input bit fill_bias);
    int                 r;
    logic [1:0]         kind;
    logic [FIELD_W-1:0] pid;
    r = $urandom_range(0, 99);
    pid = $urandom_range(0, 1) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(0, 11) * 21);
    if (r < 3) begin
      kind = KIND_NOP;
    end else if (r < (fill_bias ? 60 : 30)) begin
      kind = KIND_INSERT;
    end else if (r < (fill_bias ? 80 : 65)) begin
      kind = KIND_REMOVE;
      if (sched_q.size() > 0 && $urandom_range(0, 3) != 0)
        pid = FIELD_W'(sched_q[$urandom_range(0, sched_q.size() - 1)].id);
    end else begin
      kind = KIND_POP;
    end
    send_op(kind, pid, PRIO_W'($urandom));
  endtask

  task automatic test_empty_queue();
    send_op(KIND_POP, 8'hFF, 8'hFF);
    send_op(KIND_REMOVE, 8'h00, 8'h00);
    send_op(KIND_NOP, 8'hA5, 8'h5A);
  endtask

  task automatic test_fill_and_overflow();
    logic [FIELD_W-1:0] fill_ids [DEPTH];
    fill_ids = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h3C, 8'hC3, 8'h0F, 8'hF0,
                 8'h55, 8'h01, 8'h80, 8'h7E, 8'h81, 8'h10, 8'h08, 8'h42};
    for (int i = 0; i < DEPTH; i++) send_op(KIND_INSERT, fill_ids[i], ~fill_ids[i]);
    send_op(KIND_INSERT, 8'h77, 8'h88);
    send_op(KIND_NOP, 8'h00, 8'hFF);
  endtask

  task automatic test_remove_cases();
    send_op(KIND_REMOVE, 8'h55, 8'h00);
    send_op(KIND_REMOVE, 8'h99, 8'hFF);
    send_op(KIND_REMOVE, 8'h42, 8'h00);
    send_op(KIND_REMOVE, 8'h00, 8'h00);
    send_op(KIND_POP, 8'h00, 8'h00);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 300; i++) send_random_op((i / 40) % 2 == 0);
  endtask

  task automatic test_output_backpressure();
    fork
      begin
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) send_random_op(1'b1);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    for (int i = 0; i < 60; i++) send_random_op((i / 15) % 2 == 1);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_fill_and_overflow();
    test_remove_cases();
    test_random_mix();
    test_output_backpressure();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d queue operations, checked %0d replies.", items_sent, replies_seen);
    $display("Replies seen: done %0d, empty %0d, not found %0d, full %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/prq_pkg.sv
src/prq_slots.sv
src/prq_seq.sv
src/process_ready_queue.sv
bench/tb_top.sv
